// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with explicit clock and reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion on the block's own clock and reset
`define ASSERT_STD(lbl, prop, msg) \
   `ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

// ===== design/nau_pkg.sv =====
// ----------------------------------------------------------------------------
// nau_pkg
// Types, constants and pipeline taps of the neural activation unit.
// ----------------------------------------------------------------------------
package nau_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned KIND_W = 3;

   // Activation kinds (codes above rectifier act as linear)
   localparam logic [KIND_W-1:0] KIND_LOGISTIC = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TANH     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_STANH    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RELU     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LINEAR   = 3'd4;

   // Function select
   localparam logic FUNC_FORWARD = 1'b0;
   localparam logic FUNC_DERIV   = 1'b1;

   // Fixed-point constants
   localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;
   localparam logic [31:0] LN2_Q32      = 32'hB172_17F8;
   localparam logic [32:0] EXP_CUTOFF   = 33'd1572864;
   localparam int unsigned EXP_Y_W      = 21;
   localparam int unsigned RECIP_W      = 17;
   localparam logic [RECIP_W-1:0] EXP_RECIP = RECIP_W'((64'd1 << 48) / 64'hB172_17F8);
   localparam int unsigned K_W          = 6;
   localparam int unsigned EXP_W        = 33;
   localparam logic [31:0] STAN_IN_Q32  = 32'd2863311545;
   localparam logic [32:0] STAN_OUT_Q32 = 33'd7369734383;
   localparam logic signed [35:0] STAN_SQ_Q32  = 36'sd12645727228;
   localparam logic signed [24:0] STAN_DER_Q24 = 25'sd6518335;

   // Pipeline geometry
   localparam int unsigned TAYLOR_TERMS = 10;
   localparam int unsigned EXP_LAT  = 3 + 3 * (TAYLOR_TERMS - 1) + 1;
   localparam int unsigned QUO_W    = 17;
   localparam int unsigned DIV_LAT  = 1 + QUO_W;
   localparam int unsigned DER_LAT  = 5;
   localparam int unsigned ETAP     = 2 + EXP_LAT;
   localparam int unsigned QTAP     = ETAP + DIV_LAT;
   localparam int unsigned SIDE_LEN = QTAP + 3;

   // Item state that rides along the pipeline
   typedef struct packed {
      logic                     valid;
      logic                     func;
      logic [KIND_W-1:0]        kind;
      logic signed [DATA_W-1:0] operand;
   } side_type;

endpackage

// ===== design/nau_if.sv =====
// ----------------------------------------------------------------------------
// nau interfaces
// Valid/ready channels for request, response and configuration.
// ----------------------------------------------------------------------------
interface nau_req_if;
   logic                             valid;
   logic                             ready;
   logic                             func;
   logic signed [nau_pkg::DATA_W-1:0] operand;
   modport source (output valid, output func, output operand, input ready);
   modport sink   (input valid, input func, input operand, output ready);
endinterface

interface nau_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [nau_pkg::DATA_W-1:0] result;
   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

interface nau_csr_if;
   logic                         valid;
   logic                         ready;
   logic [nau_pkg::KIND_W-1:0]   activation_kind;
   modport source (output valid, output activation_kind, input ready);
   modport sink   (input valid, input activation_kind, output ready);
endinterface

// ===== design/nau_taylor.sv =====
// ----------------------------------------------------------------------------
// nau_taylor
// One Taylor term of e^-r: term = floor(term*r/2^32)/DIV, added to the sum (subtracted for odd DIV).
// ----------------------------------------------------------------------------
module nau_taylor #(
   parameter int unsigned DIV = 2
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [31:0]               term_i,
   input  logic [31:0]               r_i,
   input  logic [32:0]               sum_i,
   input  logic [nau_pkg::K_W-1:0]   k_i,
   input  logic                      cut_i,
   output logic [31:0]               term_o,
   output logic [31:0]               r_o,
   output logic [32:0]               sum_o,
   output logic [nau_pkg::K_W-1:0]   k_o,
   output logic                      cut_o
);
   import nau_pkg::*;

   localparam logic [31:0] MUL = 32'((64'd1 << 32) / DIV);
   localparam bit          SUB = (DIV % 2) == 1;

   logic [63:0]    prod_in;
   logic [31:0]    pa_ff, pb_ff;
   logic [63:0]    qprod_in;
   logic [31:0]    q0_ff;
   logic [35:0]    nq, rem;
   logic [31:0]    term_in, term_ff;
   logic [32:0]    sum_in;
   logic [31:0]    r_ff [0:2];
   logic [32:0]    sum_ff [0:2];
   logic [K_W-1:0] k_ff [0:2];
   logic           cut_ff [0:2];

   // Multiply by the reduced argument
   assign prod_in  = 64'(term_i) * 64'(r_i);
   // Divide by the term index through its reciprocal
   assign qprod_in = 64'(pa_ff) * 64'(MUL);
   // Correct the estimate and accumulate with alternating sign
   assign nq      = 36'(q0_ff) * 36'(DIV);
   assign rem     = 36'(pb_ff) - nq;
   assign term_in = (rem >= 36'(DIV)) ? q0_ff + 32'd1 : q0_ff;
   assign sum_in  = SUB ? sum_ff[1] - 33'(term_in) : sum_ff[1] + 33'(term_in);

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff     <= prod_in[63:32];
         q0_ff     <= qprod_in[63:32];
         pb_ff     <= pa_ff;
         term_ff   <= term_in;
         r_ff[0]   <= r_i;
         r_ff[1]   <= r_ff[0];
         r_ff[2]   <= r_ff[1];
         sum_ff[0] <= sum_i;
         sum_ff[1] <= sum_ff[0];
         sum_ff[2] <= sum_in;
         k_ff[0]   <= k_i;
         k_ff[1]   <= k_ff[0];
         k_ff[2]   <= k_ff[1];
         cut_ff[0] <= cut_i;
         cut_ff[1] <= cut_ff[0];
         cut_ff[2] <= cut_ff[1];
      end
   end

   assign term_o = term_ff;
   assign r_o    = r_ff[2];
   assign sum_o  = sum_ff[2];
   assign k_o    = k_ff[2];
   assign cut_o  = cut_ff[2];

endmodule

// ===== design/nau_exp.sv =====
// ----------------------------------------------------------------------------
// nau_exp
// Pipelined e^-y in Q32 for a Q16.16 magnitude: ln2 range reduction,
// ten-term Taylor series, final shift by the exponent.
// ----------------------------------------------------------------------------
module nau_exp (
   input  logic                            clock,
   input  logic                            en,
   input  logic [nau_pkg::EXP_Y_W-1:0]     y,
   input  logic                            cut,
   output logic [nau_pkg::EXP_W-1:0]       e
);
   import nau_pkg::*;

   localparam int unsigned KPROD_W = EXP_Y_W + RECIP_W;
   localparam int unsigned KL_W    = EXP_Y_W + 17;

   logic [KPROD_W-1:0] kprod_in, kprod_ff;
   logic [EXP_Y_W-1:0] y1_ff, y2_ff;
   logic               cut1_ff, cut2_ff, cut3_ff;
   logic [K_W-1:0]     kest;
   logic [KL_W-1:0]    kl_in, kl_ff;
   logic [K_W-1:0]     kest2_ff;
   logic [KL_W-2:0]    y32;
   logic [KL_W-1:0]    r0;
   logic               ge;
   logic [31:0]        r_in, r_ff;
   logic [K_W-1:0]     k_in, k_ff;
   logic [31:0]        term_w [1:TAYLOR_TERMS];
   logic [31:0]        r_w    [1:TAYLOR_TERMS];
   logic [32:0]        sum_w  [1:TAYLOR_TERMS];
   logic [K_W-1:0]     k_w    [1:TAYLOR_TERMS];
   logic               cut_w  [1:TAYLOR_TERMS];
   logic [EXP_W-1:0]   e_in, e_ff;

   // Estimate the ln2 multiple (never above, at most one below)
   assign kprod_in = KPROD_W'(y) * KPROD_W'(EXP_RECIP);
   assign kest     = kprod_ff[KPROD_W-1:32];
   assign kl_in    = KL_W'(kest) * KL_W'(LN2_Q32);

   // Form the remainder and fix the estimate
   assign y32  = {y2_ff, 16'd0};
   assign r0   = KL_W'(y32) - kl_ff;
   assign ge   = r0 >= KL_W'(LN2_Q32);
   assign r_in = ge ? 32'(r0 - KL_W'(LN2_Q32)) : 32'(r0);
   assign k_in = ge ? kest2_ff + K_W'(1) : kest2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         kprod_ff <= kprod_in;
         y1_ff    <= y;
         cut1_ff  <= cut;
         kl_ff    <= kl_in;
         kest2_ff <= kest;
         y2_ff    <= y1_ff;
         cut2_ff  <= cut1_ff;
         r_ff     <= r_in;
         k_ff     <= k_in;
         cut3_ff  <= cut2_ff;
         e_ff     <= e_in;
      end
   end

   // First term is the remainder itself
   assign term_w[1] = r_ff;
   assign r_w[1]    = r_ff;
   assign sum_w[1]  = ONE_Q32 - 33'(r_ff);
   assign k_w[1]    = k_ff;
   assign cut_w[1]  = cut3_ff;

   for (genvar n = 2; n <= TAYLOR_TERMS; n++) begin : g_term
      nau_taylor #(.DIV(n)) u_term (
         .clock  (clock),
         .en     (en),
         .term_i (term_w[n-1]),
         .r_i    (r_w[n-1]),
         .sum_i  (sum_w[n-1]),
         .k_i    (k_w[n-1]),
         .cut_i  (cut_w[n-1]),
         .term_o (term_w[n]),
         .r_o    (r_w[n]),
         .sum_o  (sum_w[n]),
         .k_o    (k_w[n]),
         .cut_o  (cut_w[n])
      );
   end

   // Scale by 2^-k, or drop to zero past the cutoff
   assign e_in = cut_w[TAYLOR_TERMS] ? '0 : EXP_W'(sum_w[TAYLOR_TERMS] >> k_w[TAYLOR_TERMS]);
   assign e    = e_ff;

endmodule

// ===== design/nau_div.sv =====
// ----------------------------------------------------------------------------
// nau_div
// Pipelined restoring divider: round(num * 2^16 / den), one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module nau_div (
   input  logic                         clock,
   input  logic                         en,
   input  logic [32:0]                  num,
   input  logic [33:0]                  den,
   output logic [nau_pkg::QUO_W-1:0]    quo
);
   import nau_pkg::*;

   localparam int unsigned N_W = 49;

   logic [N_W-1:0]   n_in;
   logic [33:0]      rem_ff [0:QUO_W];
   logic [QUO_W-1:0] low_ff [0:QUO_W];
   logic [QUO_W-1:0] quo_ff [0:QUO_W];
   logic [33:0]      den_ff [0:QUO_W];

   // Scale the numerator and add half the divisor for rounding
   assign n_in = (N_W'(num) << 16) + N_W'(den >> 1);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= 34'(n_in[N_W-1:QUO_W]);
         low_ff[0] <= n_in[QUO_W-1:0];
         quo_ff[0] <= '0;
         den_ff[0] <= den;
      end
   end

   for (genvar i = 1; i <= QUO_W; i++) begin : g_bit
      logic [34:0]      shifted;
      logic             take;
      logic [33:0]      rem_in;
      logic [QUO_W-1:0] quo_in;

      // Bring down one bit and try the subtraction
      assign shifted = {rem_ff[i-1], low_ff[i-1][QUO_W-1]};
      assign take    = shifted >= {1'b0, den_ff[i-1]};
      assign rem_in  = take ? 34'(shifted - {1'b0, den_ff[i-1]}) : 34'(shifted);
      assign quo_in  = {quo_ff[i-1][QUO_W-2:0], take};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            low_ff[i] <= {low_ff[i-1][QUO_W-2:0], 1'b0};
            quo_ff[i] <= quo_in;
            den_ff[i] <= den_ff[i-1];
         end
      end
   end

   assign quo = quo_ff[QUO_W];

endmodule

// ===== design/nau_deriv.sv =====
// ----------------------------------------------------------------------------
// nau_deriv
// Five-stage derivative of each activation kind, taken from its output.
// ----------------------------------------------------------------------------
module nau_deriv (
   input  logic                               clock,
   input  logic                               en,
   input  nau_pkg::side_type                  item,
   output logic signed [nau_pkg::DATA_W-1:0]  der
);
   import nau_pkg::*;

   localparam logic signed [52:0] DIFF_HI = 53'sd68719476736;
   localparam logic signed [52:0] ONE_Q16 = 53'sd65536;
   localparam logic signed [63:0] SAT_HI  = 64'sd2147483647;
   localparam logic signed [63:0] SAT_LO  = -64'sd2147483648;

   logic signed [33:0]       a, b;
   logic signed [67:0]       prod_in, prod1_ff;
   logic signed [67:0]       w_in, w2_ff;
   logic signed [67:0]       rsum;
   logic signed [51:0]       rs;
   logic signed [52:0]       d_in, d3_ff;
   logic signed [37:0]       dclip;
   logic signed [63:0]       m_in, m4_ff;
   logic signed [63:0]       msum, v;
   logic signed [DATA_W-1:0] out_in, out_ff;
   logic [KIND_W-1:0]        kind_ff [1:4];
   logic signed [DATA_W-1:0] z_ff [1:2];

   // Square the output, or z*(1-z) for the logistic
   assign a       = 34'(item.operand);
   assign b       = (item.kind == KIND_LOGISTIC) ? 34'sd65536 - a : a;
   assign prod_in = 68'(a) * 68'(b);

   // Subtract from the squared gain for the scaled tanh
   assign w_in = (kind_ff[1] == KIND_STANH) ? 68'(STAN_SQ_Q32) - prod1_ff : prod1_ff;

   // Round to Q16.16 half away from zero and finish each kind
   assign rsum = w2_ff + (w2_ff[67] ? 68'sd32767 : 68'sd32768);
   assign rs   = 52'(rsum >>> 16);

   always_comb begin
      unique case (kind_ff[2])
         KIND_LOGISTIC: d_in = 53'(rs);
         KIND_TANH:     d_in = ONE_Q16 - 53'(rs);
         KIND_STANH: begin
            if (53'(rs) > DIFF_HI) begin
               d_in = DIFF_HI;
            end else if (53'(rs) < -DIFF_HI) begin
               d_in = -DIFF_HI;
            end else begin
               d_in = 53'(rs);
            end
         end
         KIND_RELU:     d_in = (z_ff[2] > 32'sd0) ? ONE_Q16 : 53'sd0;
         default:       d_in = ONE_Q16;
      endcase
   end

   // Apply the slope factor of the scaled tanh
   assign dclip = d3_ff[37:0];
   assign m_in  = (kind_ff[3] == KIND_STANH) ? 64'(dclip) * 64'(STAN_DER_Q24) : 64'(d3_ff);

   // Round the factor product and saturate
   assign msum = m4_ff + (m4_ff[63] ? 64'sd8388607 : 64'sd8388608);
   assign v    = (kind_ff[4] == KIND_STANH) ? (msum >>> 24) : m4_ff;

   always_comb begin
      priority if (v > SAT_HI) begin
         out_in = 32'sh7FFF_FFFF;
      end else if (v < SAT_LO) begin
         out_in = 32'sh8000_0000;
      end else begin
         out_in = 32'(v);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod1_ff   <= prod_in;
         kind_ff[1] <= item.kind;
         z_ff[1]    <= item.operand;
         w2_ff      <= w_in;
         kind_ff[2] <= kind_ff[1];
         z_ff[2]    <= z_ff[1];
         d3_ff      <= d_in;
         kind_ff[3] <= kind_ff[2];
         m4_ff      <= m_in;
         kind_ff[4] <= kind_ff[3];
         out_ff     <= out_in;
      end
   end

   assign der = out_ff;

endmodule

// ===== design/neural_activation_unit.sv =====
// ----------------------------------------------------------------------------
// neural_activation_unit
// Q16.16 activation and derivative unit: logistic, tanh, scaled tanh,
// rectifier and linear, fully pipelined.
// ----------------------------------------------------------------------------
//
//   channel    direction   payload                      handshake
//   req_port   in          func, operand                valid / ready
//   rsp_port   out         result                       valid / ready
//   csr_port   in          activation_kind              valid / ready (always ready)
//
// One request per cycle while no result waits on rsp_port. The depth is set by
// the exponential (range reduction plus nine three-stage Taylor terms) and the
// 18-stage rounding divider.
// Reset empties the pipeline and sets the kind to linear.
// While a result waits on rsp_port the whole pipeline holds in place.
//
`include "assert_macros.svh"

module neural_activation_unit (
   input  logic           clock,
   input  logic           reset,
   nau_req_if.sink        req_port,
   nau_rsp_if.source      rsp_port,
   nau_csr_if.sink        csr_port
);
   import nau_pkg::*;

   logic                     en;
   logic [KIND_W-1:0]        kind_in, kind_ff;
   side_type                 side_in;
   side_type                 side_ff [0:SIDE_LEN-1];
   logic signed [DATA_W-1:0] op0;
   logic [31:0]              mag_in, mag1_ff;
   logic [63:0]              produ_in, produ_ff;
   logic [63:0]              usum;
   logic [32:0]              y_full;
   logic [EXP_Y_W-1:0]       y_in, y_ff;
   logic                     cut_in, cut_ff;
   logic [EXP_W-1:0]         e;
   logic [32:0]              num;
   logic [33:0]              den;
   logic [QUO_W-1:0]         quo;
   logic [49:0]              tprod_in, tprod_ff;
   logic [QUO_W-1:0]         quo1_ff;
   logic [49:0]              tsum;
   logic signed [DATA_W-1:0] qmag, tmag, op_t2;
   logic                     neg_t2;
   logic signed [DATA_W-1:0] fwd_in, fwd_ff;
   logic signed [DATA_W-1:0] der;
   logic                     rsp_valid_in, rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_result_in, rsp_result_ff;
   logic                     tanh_fwd_out;
   logic                     tanh_in_range;

   // Advance everything unless a result is waiting
   assign en             = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = en;

   // Activation kind register
   assign csr_port.ready = 1'b1;
   assign kind_in        = csr_port.valid ? csr_port.activation_kind : kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_LINEAR;
      end else begin
         kind_ff <= kind_in;
      end
   end

   // Side line: valid, func, kind and operand travel with each request
   assign side_in = '{valid: req_port.valid, func: req_port.func, kind: kind_ff,
                      operand: req_port.operand};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SIDE_LEN; i++) begin
            side_ff[i].valid <= 1'b0;
         end
      end else if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < SIDE_LEN; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Stage 1: magnitude and input scaling of the scaled tanh
   assign op0      = side_ff[0].operand;
   assign mag_in   = op0[31] ? 32'(-op0) : 32'(op0);
   assign produ_in = 64'(mag_in) * 64'(STAN_IN_Q32);

   // Stage 2: exponent argument per kind (logistic e^-|x|, tanh e^-2a)
   assign usum = produ_ff + 64'h8000_0000;

   always_comb begin
      unique case (side_ff[1].kind)
         KIND_TANH:  y_full = {mag1_ff, 1'b0};
         KIND_STANH: y_full = {usum[63:32], 1'b0};
         default:    y_full = 33'(mag1_ff);
      endcase
   end

   // From 24.0 up the exponential is zero; this also covers the logistic
   // limits at -45 and +45
   assign cut_in = y_full >= EXP_CUTOFF;
   assign y_in   = y_full[EXP_Y_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff  <= mag_in;
         produ_ff <= produ_in;
         y_ff     <= y_in;
         cut_ff   <= cut_in;
      end
   end

   nau_exp u_exp (
      .clock (clock),
      .en    (en),
      .y     (y_ff),
      .cut   (cut_ff),
      .e     (e)
   );

   // Ratio operands: tanh (1-E)/(1+E), logistic 1/(1+E) or E/(1+E)
   assign den = 34'(ONE_Q32) + 34'(e);
   assign num = (side_ff[ETAP].kind == KIND_LOGISTIC) ?
                (side_ff[ETAP].operand[31] ? e : ONE_Q32) : ONE_Q32 - e;

   nau_div u_div (
      .clock (clock),
      .en    (en),
      .num   (num),
      .den   (den),
      .quo   (quo)
   );

   // Output scaling of the scaled tanh
   assign tprod_in = 50'(quo) * 50'(STAN_OUT_Q32);

   always_ff @(posedge clock) begin
      if (en) begin
         tprod_ff <= tprod_in;
         quo1_ff  <= quo;
      end
   end

   // Select the forward result and restore the sign
   assign tsum   = tprod_ff + 50'h8000_0000;
   assign qmag   = 32'(quo1_ff);
   assign tmag   = 32'(tsum[49:32]);
   assign op_t2  = side_ff[QTAP+1].operand;
   assign neg_t2 = op_t2[31];

   always_comb begin
      unique case (side_ff[QTAP+1].kind)
         KIND_LOGISTIC: fwd_in = qmag;
         KIND_TANH:     fwd_in = neg_t2 ? -qmag : qmag;
         KIND_STANH:    fwd_in = neg_t2 ? -tmag : tmag;
         KIND_RELU:     fwd_in = (op_t2 > 32'sd0) ? op_t2 : 32'sd0;
         default:       fwd_in = op_t2;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fwd_ff <= fwd_in;
      end
   end

   nau_deriv u_deriv (
      .clock (clock),
      .en    (en),
      .item  (side_ff[QTAP+2-DER_LAT]),
      .der   (der)
   );

   // Response register
   assign rsp_valid_in  = side_ff[QTAP+2].valid;
   assign rsp_result_in = (side_ff[QTAP+2].func == FUNC_DERIV) ? der : fwd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

   assign rsp_port.valid  = rsp_valid_ff;
   assign rsp_port.result = rsp_result_ff;

   // Forward tanh results stay within one in magnitude
   assign tanh_fwd_out  = side_ff[QTAP+2].valid && (side_ff[QTAP+2].kind == KIND_TANH) &&
                          (side_ff[QTAP+2].func == FUNC_FORWARD);
   assign tanh_in_range = (fwd_ff <= 32'sd65536) && (fwd_ff >= -32'sd65536);

   `ASSERT_STD(a_exp_range, side_ff[ETAP].valid |-> (e <= ONE_Q32), "exponential above one")
   `ASSERT_STD(a_quo_range, side_ff[QTAP].valid |-> (quo <= 17'd65536), "ratio above one")
   `ASSERT_STD(a_tanh_range, tanh_fwd_out |-> tanh_in_range, "tanh out of range")

endmodule

// ===== test/neural_activation_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neural_activation_unit_checker
// Watches the request, response and register channels, predicts every
// Q16.16 activation or derivative and compares it with the response stream.
// ----------------------------------------------------------------------------
module neural_activation_unit_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_func,
   input  logic signed [nau_pkg::DATA_W-1:0] req_operand,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [nau_pkg::DATA_W-1:0] rsp_result,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [nau_pkg::KIND_W-1:0]        csr_activation_kind,
   output int                                fail_count,
   output int                                results_pending
);
   import nau_pkg::*;

   localparam longint ONE_Q16    = 64'sd65536;
   localparam longint LOGI_EDGE  = 64'sd45 <<< 16;
   localparam longint DIFF_CLAMP = 64'sd1 <<< 36;

   logic [KIND_W-1:0]        kind_q;
   logic signed [DATA_W-1:0] activation_q[$];

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Round v / 2^s half away from zero
   function automatic longint round_away(longint v, int s);
      logic [63:0] m;
      m = (v < 0) ? 64'(-v) : 64'(v);
      m = (m + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   // e^-y for unsigned Q16.16 y, result in Q32
   function automatic logic [63:0] exp_neg(logic [63:0] y);
      logic [63:0] y32, k, r, term, sum;
      if (y >= (64'd24 << 16)) return 64'd0;
      y32 = y << 16;
      k = y32 / 64'hB172_17F8;
      r = y32 - k * 64'hB172_17F8;
      term = 64'd1 << 32;
      sum = 64'd1 << 32;
      for (int n = 1; n <= 10; n++) begin
         term = ((term * r) >> 32) / 64'(n);
         if (n % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      return sum >> k;
   endfunction

   function automatic logic [63:0] ratio16(logic [63:0] num, logic [63:0] den);
      return ((num << 16) + den / 2) / den;
   endfunction

   function automatic logic [63:0] tanh_mag(logic [63:0] a);
      logic [63:0] e;
      e = exp_neg(2 * a);
      return ratio16((64'd1 << 32) - e, (64'd1 << 32) + e);
   endfunction

   function automatic longint activation_of(logic [KIND_W-1:0] kind, logic fn,
                                            longint x);
      logic [63:0] mag, e, u, th;
      longint t;
      mag = (x < 0) ? 64'(-x) : 64'(x);
      if (fn == FUNC_DERIV) begin
         case (kind)
            KIND_LOGISTIC: return clamp32(round_away(x * (ONE_Q16 - x), 16));
            KIND_TANH:     return clamp32(ONE_Q16 - round_away(x * x, 16));
            KIND_STANH: begin
               t = round_away(64'sd12645727228 - x * x, 16);
               if (t > DIFF_CLAMP) t = DIFF_CLAMP;
               if (t < -DIFF_CLAMP) t = -DIFF_CLAMP;
               return clamp32(round_away(t * 64'sd6518335, 24));
            end
            KIND_RELU:     return (x > 0) ? ONE_Q16 : 64'sd0;
            default:       return ONE_Q16;
         endcase
      end
      case (kind)
         KIND_LOGISTIC: begin
            if (x < -LOGI_EDGE) return 0;
            if (x > LOGI_EDGE) return ONE_Q16;
            e = exp_neg(mag);
            if (x >= 0) return longint'(ratio16(64'd1 << 32, (64'd1 << 32) + e));
            return longint'(ratio16(e, (64'd1 << 32) + e));
         end
         KIND_TANH: begin
            t = longint'(tanh_mag(mag));
            return (x < 0) ? -t : t;
         end
         KIND_STANH: begin
            u = (mag * 64'd2863311545 + (64'd1 << 31)) >> 32;
            th = tanh_mag(u);
            t = longint'((th * 64'd7369734383 + (64'd1 << 31)) >> 32);
            return (x < 0) ? -t : t;
         end
         KIND_RELU: return (x > 0) ? x : 64'sd0;
         default:   return x;
      endcase
   endfunction

   assign results_pending = activation_q.size();

   // Track the register, predict on each request, compare on each response
   always @(posedge clock) begin
      logic signed [DATA_W-1:0] want;
      if (reset) begin
         kind_q <= KIND_LINEAR;
         activation_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) kind_q <= csr_activation_kind;
         if (req_valid && req_ready)
            activation_q.push_back(DATA_W'(activation_of(kind_q, req_func,
                                                         longint'(req_operand))));
         if (rsp_valid && rsp_ready) begin
            if (activation_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %h", rsp_result);
               fail_count <= fail_count + 1;
            end else begin
               want = activation_q.pop_front();
               if (want !== rsp_result) begin
                  if (fail_count < 10)
                     $display("result mismatch: expected %h actual %h", want, rsp_result);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== test/neural_activation_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neural_activation_unit_tb
// Runs every activation kind with edge operands and random bursts of
// requests under random response stalls and one long hold-off.
// ----------------------------------------------------------------------------
module neural_activation_unit_tb;
   import nau_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 80;

   logic clock;
   logic reset;
   int   cycles;
   int   fail_count;
   int   results_pending;
   bit   stall_mode;

   nau_req_if req_bus ();
   nau_rsp_if rsp_bus ();
   nau_csr_if csr_bus ();

   neural_activation_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus.sink),
      .rsp_port (rsp_bus.source),
      .csr_port (csr_bus.sink)
   );

   neural_activation_unit_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_bus.valid),
      .req_ready           (req_bus.ready),
      .req_func            (req_bus.func),
      .req_operand         (req_bus.operand),
      .rsp_valid           (rsp_bus.valid),
      .rsp_ready           (rsp_bus.ready),
      .rsp_result          (rsp_bus.result),
      .csr_valid           (csr_bus.valid),
      .csr_ready           (csr_bus.ready),
      .csr_activation_kind (csr_bus.activation_kind),
      .fail_count          (fail_count),
      .results_pending     (results_pending)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Stop a hung run
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[neural_activation_unit] ERROR");
         $finish;
      end
   end

   // Drive response ready: switch patterns, with one long hold-off
   initial begin
      int hold_left;
      int pattern_left;
      int pct;
      hold_left = 0;
      pattern_left = 0;
      pct = 100;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(20, 200);
            case ($urandom_range(0, 3))
               0: pct = 100;
               1: pct = 50;
               2: pct = 85;
               default: pct = 20;
            endcase
         end
         pattern_left--;
         if (stall_mode && hold_left == 0) hold_left = 400;
         if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) stall_mode = 1'b0;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(1, 100) <= pct);
         end
      end
   end

   // Offer one request and hold it until accepted
   task automatic send_request(logic fn, logic signed [DATA_W-1:0] value);
      req_bus.valid   <= 1'b1;
      req_bus.func    <= fn;
      req_bus.operand <= value;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic pause(int n);
      req_bus.valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // Write the kind once the pipeline has drained
   task automatic write_kind(logic [KIND_W-1:0] kind);
      pause(1);
      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      csr_bus.valid           <= 1'b1;
      csr_bus.activation_kind <= kind;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic signed [DATA_W-1:0] random_operand();
      case ($urandom_range(0, 5))
         0, 1: return DATA_W'($urandom());
         2:    return DATA_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         3:    return DATA_W'($signed($urandom_range(0, 3 << 16)) - (3 << 15));
         4:    return DATA_W'($signed($urandom_range(0, 1 << 18)) + (44 << 16)) *
                      ($urandom_range(0, 1) ? 1 : -1);
         default: return DATA_W'($signed($urandom_range(0, 60 << 16)) - (30 << 16));
      endcase
   endfunction

   // Edge operands, both functions, then random bursts
   task automatic run_phase(int count);
      logic signed [DATA_W-1:0] edges[12];
      int left;
      int burst;
      edges = '{32'sh0, 32'sh1, -32'sh1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                32'sh002D_0000, -32'sh002D_0000, 32'sh002D_0001, -32'sh002D_0001,
                32'sh0018_0000, 32'sh0001_0000, -32'sh0001_0000};
      foreach (edges[i]) begin
         send_request(FUNC_FORWARD, edges[i]);
         send_request(FUNC_DERIV, edges[i]);
      end
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && left > 0) begin
            send_request(logic'($urandom_range(0, 1)), random_operand());
            burst--;
            left--;
         end
         if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 8));
      end
   endtask

   initial begin
      stall_mode = 1'b0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.func <= FUNC_FORWARD;
      req_bus.operand <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.activation_kind <= KIND_LINEAR;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_phase(120);
      for (int k = 0; k < 8; k++) begin
         write_kind(KIND_W'(k));
         if (k == 1) stall_mode = 1'b1;
         run_phase(160);
      end
      write_kind(KIND_STANH);
      run_phase(50);
      pause(1);

      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (fail_count == 0) begin
         $display("[neural_activation_unit] OK");
      end else begin
         $display("[neural_activation_unit] ERROR");
      end
      $finish;
   end

endmodule
